// ===== design/dde_pkg.sv =====
// Package for the decimal digit emitter: sizes, character codes,
// register indexes and the controller state type.
// No dependencies.
package dde_pkg;

    // Positions that one transaction can emit, and the conversion sizes.
    localparam int MAX_DIGITS = 10;
    localparam int VALUE_W    = 32;
    localparam int BCD_W      = 4 * MAX_DIGITS;
    localparam int CONV_CNT_W = $clog2(VALUE_W);
    localparam int COUNT_W    = 4;

    // Field widths fixed by the interface.
    localparam int CHAR_W   = 6;
    localparam int COL_IN_W = 7;
    localparam int COL_W    = 8;
    localparam int ROW_W    = 6;
    localparam int FONT_W   = 5;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 1;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 6'd32;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_FONT_HEIGHT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_POLARITY = 1'd1;
    localparam logic [FONT_W-1:0]    FONT_HEIGHT_RST   = 5'd12;
    localparam logic                 DRAW_POLARITY_RST = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

endpackage

// ===== design/decimal_digit_emitter.sv =====
// Top level of the decimal digit emitter: bit-serial binary to BCD
// conversion followed by a digit-serial character emitter.
// Depends on dde_pkg.
//
//  Channel   Signals                                        Direction
//  --------  ---------------------------------------------  ---------
//  input     i_in_valid / o_in_ready, value, count, col, row in
//  output    o_out_valid / i_out_ready, char, col, row, pol, last out
//  config    i_cfg_we, i_cfg_index, i_cfg_data               in
//
// A transaction is accepted, converted one value bit per cycle through the
// shift-and-add-3 digit register, then emitted one digit position per cycle
// while the output is free, through all MAX_DIGITS positions.
// Reset is synchronous and active low; it clears the controller, the output
// valid and the configuration registers. A stalled output holds the emitter
// in place; the input stays not ready until the last character is loaded.
module decimal_digit_emitter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dde_pkg::VALUE_W-1:0]   i_value,
    input  logic [dde_pkg::COUNT_W-1:0]   i_digit_count,
    input  logic [dde_pkg::COL_IN_W-1:0]  i_start_column,
    input  logic [dde_pkg::ROW_W-1:0]     i_row_position,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dde_pkg::CHAR_W-1:0]    o_char_code,
    output logic [dde_pkg::COL_W-1:0]     o_column_position,
    output logic [dde_pkg::ROW_W-1:0]     o_row_out,
    output logic                          o_polarity_out,
    output logic                          o_is_last,
    input  logic                          i_cfg_we,
    input  logic [dde_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dde_pkg::CFG_W-1:0]     i_cfg_data
);
    import dde_pkg::*;

    // Correct every BCD digit of 5 or more by adding 3 before the shift.
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        res = bcd;
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (bcd[4*d +: 4] >= 4'd5) begin
                res[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

    t_state                r_state, n_state;
    logic [FONT_W-1:0]     r_font_height;
    logic                  r_draw_polarity;
    logic [VALUE_W-1:0]    r_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic [CONV_CNT_W-1:0] r_conv_cnt;
    logic [COUNT_W-1:0]    r_count;
    logic [COUNT_W-1:0]    r_idx;
    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;
    logic                  r_shown;
    logic                  r_out_valid;
    logic [CHAR_W-1:0]     r_char;
    logic [COL_W-1:0]      r_col_out;
    logic [ROW_W-1:0]      r_row_out;
    logic                  r_pol_out;
    logic                  r_last_out;

    logic                  w_accept;
    logic                  w_conv;
    logic                  w_conv_done;
    logic                  w_emit;
    logic                  w_in_range;
    logic                  w_advance;
    logic                  w_load;
    logic [3:0]            w_digit;
    logic                  w_last;
    logic                  w_blank;
    logic [COUNT_W-1:0]    w_count_sat;
    logic [COL_W-1:0]      w_step;
    logic [BCD_W-1:0]      w_bcd_adj;

    // Clamp the digit count to 1..MAX_DIGITS.
    always_comb begin
        if (i_digit_count == '0) begin
            w_count_sat = COUNT_W'(1);
        end else if (i_digit_count > COUNT_W'(MAX_DIGITS)) begin
            w_count_sat = COUNT_W'(MAX_DIGITS);
        end else begin
            w_count_sat = i_digit_count;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_conv_cnt == CONV_CNT_W'(VALUE_W - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_advance && (r_idx == '0)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State-decoded controls.
    always_comb begin
        o_in_ready = 1'b0;
        w_conv     = 1'b0;
        w_emit     = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_CONV: w_conv     = 1'b1;
            ST_EMIT: w_emit     = 1'b1;
            default: o_in_ready = 1'b0;
        endcase
    end

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_conv_done = w_conv && (r_conv_cnt == CONV_CNT_W'(VALUE_W - 1));
    assign w_bcd_adj   = bcd_adjust(r_bcd);

    // Emit step: positions above the count are shifted out without a result.
    assign w_in_range = (r_idx < r_count);
    assign w_advance  = w_emit && (!w_in_range || !r_out_valid || i_out_ready);
    assign w_load     = w_advance && w_in_range;
    assign w_digit    = r_bcd[BCD_W-1 -: 4];
    assign w_last     = (r_idx == '0);
    assign w_blank    = !r_shown && !w_last && (w_digit == 4'd0);
    assign w_step     = COL_W'(r_font_height >> 1);

    // Controller and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_out_valid     <= 1'b0;
            r_font_height   <= FONT_HEIGHT_RST;
            r_draw_polarity <= DRAW_POLARITY_RST;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FONT_HEIGHT:   r_font_height   <= i_cfg_data;
                    REG_DRAW_POLARITY: r_draw_polarity <= i_cfg_data[0];
                    default:           r_font_height   <= r_font_height;
                endcase
            end
        end
    end

    // Conversion and emit datapath.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bin      <= i_value;
            r_bcd      <= '0;
            r_conv_cnt <= '0;
            r_count    <= w_count_sat;
            r_col      <= COL_W'(i_start_column);
            r_row      <= i_row_position;
            r_shown    <= 1'b0;
        end else if (w_conv) begin
            r_bcd      <= {w_bcd_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
            r_bin      <= {r_bin[VALUE_W-2:0], 1'b0};
            r_conv_cnt <= r_conv_cnt + CONV_CNT_W'(1);
        end else if (w_advance) begin
            r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
            if (w_load) begin
                r_col   <= r_col + w_step;
                r_shown <= r_shown || !w_blank;
            end
        end
        if (w_conv_done) begin
            r_idx <= COUNT_W'(MAX_DIGITS - 1);
        end else if (w_advance) begin
            r_idx <= r_idx - COUNT_W'(1);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_char     <= w_blank ? CHAR_SPACE : (CHAR_ZERO + CHAR_W'(w_digit));
            r_col_out  <= r_col;
            r_row_out  <= r_row;
            r_pol_out  <= r_draw_polarity;
            r_last_out <= w_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_char_code       = r_char;
    assign o_column_position = r_col_out;
    assign o_row_out         = r_row_out;
    assign o_polarity_out    = r_pol_out;
    assign o_is_last         = r_last_out;

    // The finished conversion always hands over to the emit state.
    a_conv_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_conv_done |=> (r_state == ST_EMIT))
        else $error("conversion did not hand over to emit");

    // The final character of a run is never blanked.
    a_last_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_last) |-> (o_char_code != CHAR_SPACE))
        else $error("last character blanked");

    // Every digit loaded into the output register is a valid decimal digit.
    a_bcd_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (w_digit <= 4'd9))
        else $error("invalid BCD digit emitted");

    // A new transaction is never accepted twice in a row.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("input accepted during conversion");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for decimal_digit_emitter: drives numbers over the
// input channel and checks every emitted character against a local predictor.
// Depends on dde_pkg and the decimal_digit_emitter RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dde_pkg::*;

    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int STALL_CYCLES   = 300;

    // One expected character, one field per output port.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              pol;
        logic              last;
    } t_char;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [VALUE_W-1:0]    i_value = '0;
    logic [COUNT_W-1:0]    i_digit_count = '0;
    logic [COL_IN_W-1:0]   i_start_column = '0;
    logic [ROW_W-1:0]      i_row_position = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [CHAR_W-1:0]     o_char_code;
    logic [COL_W-1:0]      o_column_position;
    logic [ROW_W-1:0]      o_row_out;
    logic                  o_polarity_out;
    logic                  o_is_last;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    // Register copies used by the predictor.
    logic [FONT_W-1:0]     font_height_q = FONT_HEIGHT_RST;
    logic                  polarity_q = DRAW_POLARITY_RST;

    t_char                 expected_chars[$];
    int                    errors = 0;
    bit                    calm = 1'b0;
    int                    hold_request = 0;
    int                    hold_left = 0;
    int                    out_gap = 0;
    int                    idle_cycles = 0;

    decimal_digit_emitter u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_value           (i_value),
        .i_digit_count     (i_digit_count),
        .i_start_column    (i_start_column),
        .i_row_position    (i_row_position),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_char_code       (o_char_code),
        .o_column_position (o_column_position),
        .o_row_out         (o_row_out),
        .o_polarity_out    (o_polarity_out),
        .o_is_last         (o_is_last),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [VALUE_W-1:0] ten_power(input int unsigned expo);
        logic [VALUE_W-1:0] p;
        p = 1;
        for (int k = 0; k < expo; k++) p = p * 10;
        return p;
    endfunction

    // Expand one number into its characters: saturate the count, blank the
    // leading zeros, always show the final digit, step the column by half the font.
    function automatic void predict_chars(input logic [VALUE_W-1:0] value,
                                          input logic [COUNT_W-1:0] count,
                                          input logic [COL_IN_W-1:0] col0,
                                          input logic [ROW_W-1:0] row);
        int unsigned   n;
        int unsigned   digit;
        bit            shown;
        logic [COL_W-1:0] step;
        t_char         c;
        n = 32'(count);
        if (n < 1) n = 1;
        if (n > MAX_DIGITS) n = MAX_DIGITS;
        shown = 1'b0;
        step = COL_W'(font_height_q >> 1);
        for (int unsigned t = 0; t < n; t++) begin
            digit = (value / ten_power(n - 1 - t)) % 10;
            c.last = (t == n - 1);
            if (!shown && !c.last && digit == 0) begin
                c.code = CHAR_SPACE;
            end else begin
                shown = 1'b1;
                c.code = CHAR_ZERO + CHAR_W'(digit);
            end
            c.col = COL_W'(col0) + COL_W'(step * t);
            c.row = row;
            c.pol = polarity_q;
            expected_chars.push_back(c);
        end
    endfunction

    // Offer one number after a random gap and hold it until accepted.
    task automatic send_number(input logic [VALUE_W-1:0] value,
                               input logic [COUNT_W-1:0] count,
                               input logic [COL_IN_W-1:0] col,
                               input logic [ROW_W-1:0] row);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_value        <= value;
        i_digit_count  <= count;
        i_start_column <= col;
        i_row_position <= row;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predict_chars(value, count, col, row);
    endtask

    // Random number biased toward values with leading zeros and the top end;
    // about one count in ten lies outside 1..10.
    task automatic send_random_number;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        case ($urandom_range(0, 4))
            0: value = $urandom;
            1: value = $urandom_range(0, 9);
            2: value = $urandom_range(0, 99999);
            3: value = ten_power($urandom_range(0, 9)) * $urandom_range(1, 4);
            default: value = 32'hFFFF_FFFF - $urandom_range(0, 1000);
        endcase
        if ($urandom_range(0, 9) == 0) begin
            count = COUNT_W'($urandom_range(0, 5));
            if (count != 0) count = COUNT_W'(count + 10);
        end else begin
            count = COUNT_W'($urandom_range(1, MAX_DIGITS));
        end
        send_number(value, count, COL_IN_W'($urandom_range(0, 127)),
                    ROW_W'($urandom_range(0, 63)));
    endtask

    // Drop valid, wait for every character to come out, then let the block settle.
    task automatic wait_idle;
        i_in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_FONT_HEIGHT) font_height_q = data;
        else polarity_q = data[0];
        @(posedge i_clk);
    endtask

    // Only bit 0 of the polarity word matters; the upper bits are random.
    task automatic apply_config(input logic [FONT_W-1:0] font, input logic pol);
        logic [CFG_W-1:0] pol_word;
        pol_word = CFG_W'($urandom);
        pol_word[0] = pol;
        wait_idle();
        write_reg(REG_FONT_HEIGHT, font);
        write_reg(REG_DRAW_POLARITY, pol_word);
    endtask

    // Directed cases at the reset register values.
    task automatic test_directed;
        send_number(32'd0, 4'd1, 7'd0, 6'd0);
        send_number(32'd0, 4'd10, 7'd127, 6'd63);
        send_number(32'hFFFF_FFFF, 4'd10, 7'd0, 6'd63);
        send_number(32'hFFFF_FFFF, 4'd15, 7'd127, 6'd0);
        send_number(32'd7, 4'd0, 7'd5, 6'd21);
        send_number(32'd1234567890, 4'd11, 7'd64, 6'd42);
        send_number(32'd1000000000, 4'd10, 7'd100, 6'd1);
        send_number(32'd12345, 4'd3, 7'd3, 6'd2);
        send_number(32'd1000, 4'd3, 7'd10, 6'd3);
        send_number(32'd100, 4'd5, 7'd20, 6'd4);
        send_number(32'd1, 4'd10, 7'd30, 6'd5);
        send_number(32'd10, 4'd2, 7'd40, 6'd6);
        send_number(32'h8000_0000, 4'd10, 7'd85, 6'd42);
        send_number(32'd9, 4'd1, 7'd127, 6'd63);
        send_number(32'h5555_5555, 4'd12, 7'd42, 6'd21);
        send_number(32'hAAAA_AAAA, 4'd14, 7'd85, 6'd42);
    endtask

    // Sweep the font register through the standard sizes, the extremes and
    // odd values, with the polarity alternating.
    task automatic test_font_and_polarity;
        logic [FONT_W-1:0] fonts [8] = '{5'd12, 5'd16, 5'd24, 5'd0, 5'd31, 5'd1, 5'd17, 5'd10};
        for (int k = 0; k < 8; k++) begin
            apply_config(fonts[k], k[0]);
            repeat (26) send_random_number();
        end
    endtask

    // Stall the output for a long stretch while numbers keep coming, so the
    // block fills and holds off its input.
    task automatic test_output_stall;
        wait_idle();
        calm = 1'b1;
        hold_request = STALL_CYCLES;
        repeat (8) send_random_number();
        calm = 1'b0;
    endtask

    // Random numbers in phases; one phase runs without gaps on either side.
    task automatic test_random_numbers;
        logic [FONT_W-1:0] font;
        for (int phase = 0; phase < 5; phase++) begin
            case ($urandom_range(0, 3))
                0: font = 5'd12;
                1: font = 5'd16;
                2: font = 5'd24;
                default: font = FONT_W'($urandom_range(0, 31));
            endcase
            apply_config(font, 1'($urandom_range(0, 1)));
            calm = (phase == 2);
            repeat (50) send_random_number();
        end
        calm = 1'b0;
    endtask

    // Output side: random pause after each transaction, plus the long hold-off.
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (o_out_valid === 1'b1 && i_out_ready) out_gap = calm ? 0 : $urandom_range(0, 3);
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Compare every accepted character with the oldest prediction.
    always @(posedge i_clk) begin : char_check
        t_char exp_c;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t ns: unexpected character, expected none, actual code %0d col %0d",
                         $time, o_char_code, o_column_position);
                errors++;
            end else begin
                exp_c = expected_chars.pop_front();
                check_field("char_code", 32'(exp_c.code), 32'(o_char_code));
                check_field("column_position", 32'(exp_c.col), 32'(o_column_position));
                check_field("row_out", 32'(exp_c.row), 32'(o_row_out));
                check_field("polarity_out", 32'(exp_c.pol), 32'(o_polarity_out));
                check_field("is_last", 32'(exp_c.last), 32'(o_is_last));
            end
        end
    end

    // Watchdog: too many cycles without any transaction on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_font_and_polarity();
        test_output_stall();
        test_random_numbers();
        wait_idle();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/dde_pkg.sv
design/decimal_digit_emitter.sv
tb/tb_top.sv
